// File: design/ptt_pkg.sv
// Package for the periodic timer table: item structs, table row layout,
// operation and result codes, and sequencer states. No dependencies.
package ptt_pkg;

  localparam int KIND_W      = 2;
  localparam int PERIOD_W    = 24;
  localparam int HANDLER_W   = 16;
  localparam int COUNT_W     = 25;
  localparam int DECR_W      = 10;
  localparam int MAX_RESULTS = 64;
  localparam int REP_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [DECR_W-1:0] DECR_RESET = 10'd10;

  localparam logic [KIND_W-1:0] KIND_REGISTER   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNREGISTER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK       = 2'd2;

  localparam logic [KIND_W-1:0] RK_REGISTER   = 2'd0;
  localparam logic [KIND_W-1:0] RK_UNREGISTER = 2'd1;
  localparam logic [KIND_W-1:0] RK_FIRE       = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [PERIOD_W-1:0]  period_ms;
    logic [HANDLER_W-1:0] handler_id;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    result_kind;
    logic                 success;
    logic [HANDLER_W-1:0] fired_handler;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]        period;
    logic [HANDLER_W-1:0]       handler;
    logic signed [COUNT_W-1:0]  countdown;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REG,
    S_UNR_RD,
    S_UNR_CMP,
    S_TAIL_RD,
    S_TAIL_WR,
    S_TICK_RD,
    S_TICK_WR,
    S_TICK_END,
    S_RESP
  } state_t;

endpackage

// File: design/periodic_timer_table.sv
// Top level of the periodic timer table: sequencer, countdown subtract and
// compare logic, and the entry RAM. Depends on ptt_pkg and ptt_ram.
//
// Usage:
//   in channel (in_valid/in_ready/in_data): one beat per operation. The block
//   takes a beat only when idle and works on it until all its results are out.
//   out channel (out_valid/out_ready/out_data): result beats; last marks the
//   final beat of an operation. Register and unregister give one beat each;
//   a tick gives one beat per expired timer (at most 64) and none if none
//   expired. Unused kind 3 gives nothing.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes tick_decrement; always
//   ready; it must be written only while the block is idle (not enforced).
// Sequencing: register writes an accepted entry in S_REG, then answers.
// Unregister checks entries one at a time (S_UNR_RD, S_UNR_CMP), then on a
// match moves the tail entry into the freed slot (S_TAIL_RD, S_TAIL_WR) and
// answers. A tick reads and rewrites each active entry via the single read port.
// Reset clears the entry count and loads tick_decrement with 10; the RAM
// needs no clearing. A stalled receiver holds the output register and the
// scan waits on the next expiry until the output register frees up.
module periodic_timer_table #(
  parameter int TIMER_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ptt_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [9:0]         cfg_data
);
  import ptt_pkg::*;

  localparam int IDX_W = $clog2(TIMER_SLOTS);
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  state_t               state, state_next;
  in_item_t             item;
  logic [CNT_W-1:0]     active_count;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     slot;
  logic [DECR_W-1:0]    tick_decrement;
  logic [KIND_W-1:0]    resp_kind;
  logic                 resp_ok;
  logic                 pend_valid;
  logic [HANDLER_W-1:0] pend_handler;
  logic [REP_W-1:0]     rep_count;

  logic                 ram_wr_en;
  logic [IDX_W-1:0]     ram_wr_addr;
  entry_t               ram_wr_data;
  logic [IDX_W-1:0]     ram_rd_addr;
  entry_t               rd_entry;

  logic                 in_take;
  logic                 out_free;
  logic                 out_load;
  logic [IDX_W-1:0]     tail;
  logic                 idx_is_last;
  logic                 table_full;
  logic                 reg_refused;
  logic                 match;
  logic signed [COUNT_W-1:0] diff;
  logic                 fire;
  logic                 report;
  logic                 tick_stall;
  entry_t               tick_entry;
  entry_t               new_entry;

  ptt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TIMER_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_entry)
  );

  assign cfg_ready   = 1'b1;
  assign in_take     = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign tail        = IDX_W'(active_count - CNT_W'(1));
  assign idx_is_last = (CNT_W'(idx) + CNT_W'(1)) == active_count;
  assign table_full  = active_count >= CNT_W'(TIMER_SLOTS);
  assign reg_refused = table_full || (item.period_ms == '0);
  assign match       = rd_entry.handler == item.handler_id;
  assign diff        = rd_entry.countdown - $signed({{(COUNT_W-DECR_W){1'b0}}, tick_decrement});
  assign fire        = diff[COUNT_W-1] || (diff == '0);
  assign report      = rep_count < REP_W'(MAX_RESULTS);
  assign tick_stall  = fire && report && pend_valid && !out_free;
  assign out_load    = ((state == S_TICK_WR) && !tick_stall && fire && report && pend_valid) ||
                       ((state == S_TICK_END) && pend_valid && out_free) ||
                       ((state == S_RESP) && out_free);

  always_comb begin
    tick_entry = rd_entry;
    tick_entry.countdown = fire ? $signed({1'b0, rd_entry.period}) : diff;
    new_entry.period    = item.period_ms;
    new_entry.handler   = item.handler_id;
    new_entry.countdown = $signed({1'b0, item.period_ms});
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          case (in_data.kind)
            KIND_REGISTER:   state_next = S_REG;
            KIND_UNREGISTER: state_next = (active_count == '0) ? S_RESP : S_UNR_RD;
            KIND_TICK:       state_next = (active_count == '0) ? S_IDLE : S_TICK_RD;
            default:         state_next = S_IDLE;
          endcase
        end
      end
      S_REG:     state_next = S_RESP;
      S_UNR_RD:  state_next = S_UNR_CMP;
      S_UNR_CMP: begin
        if (match) begin
          state_next = S_TAIL_RD;
        end else if (idx_is_last) begin
          state_next = S_RESP;
        end else begin
          state_next = S_UNR_RD;
        end
      end
      S_TAIL_RD: state_next = S_TAIL_WR;
      S_TAIL_WR: state_next = S_RESP;
      S_TICK_RD: state_next = S_TICK_WR;
      S_TICK_WR: begin
        if (!tick_stall) begin
          state_next = idx_is_last ? S_TICK_END : S_TICK_RD;
        end
      end
      S_TICK_END: begin
        if (!pend_valid || out_free) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == S_IDLE);
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx;
    ram_wr_data = tick_entry;
    ram_rd_addr = idx;
    case (state)
      S_REG: begin
        ram_wr_en   = !reg_refused;
        ram_wr_addr = IDX_W'(active_count);
        ram_wr_data = new_entry;
      end
      S_TAIL_RD: ram_rd_addr = tail;
      S_TAIL_WR: begin
        ram_rd_addr = tail;
        ram_wr_en   = 1'b1;
        ram_wr_addr = slot;
        ram_wr_data = rd_entry;
      end
      S_TICK_WR: ram_wr_en = !tick_stall;
      default: ram_wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      active_count   <= '0;
      tick_decrement <= DECR_RESET;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        tick_decrement <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            item       <= in_data;
            idx        <= '0;
            rep_count  <= '0;
            pend_valid <= 1'b0;
            resp_kind  <= (in_data.kind == KIND_REGISTER) ? RK_REGISTER : RK_UNREGISTER;
            resp_ok    <= 1'b0;
          end
        end
        S_REG: begin
          if (!reg_refused) begin
            active_count <= active_count + CNT_W'(1);
            resp_ok      <= 1'b1;
          end
        end
        S_UNR_CMP: begin
          if (match) begin
            slot <= idx;
          end else if (!idx_is_last) begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_TAIL_WR: begin
          active_count <= active_count - CNT_W'(1);
          resp_ok      <= 1'b1;
        end
        S_TICK_WR: begin
          if (!tick_stall) begin
            if (!idx_is_last) begin
              idx <= idx + IDX_W'(1);
            end
            if (fire && report) begin
              rep_count    <= rep_count + REP_W'(1);
              pend_valid   <= 1'b1;
              pend_handler <= rd_entry.handler;
              if (pend_valid) begin
                out_data.result_kind   <= RK_FIRE;
                out_data.success       <= 1'b1;
                out_data.fired_handler <= pend_handler;
                out_data.last          <= 1'b0;
              end
            end
          end
        end
        S_TICK_END: begin
          if (pend_valid && out_free) begin
            pend_valid             <= 1'b0;
            out_data.result_kind   <= RK_FIRE;
            out_data.success       <= 1'b1;
            out_data.fired_handler <= pend_handler;
            out_data.last          <= 1'b1;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_data.result_kind   <= resp_kind;
            out_data.success       <= resp_ok;
            out_data.fired_handler <= '0;
            out_data.last          <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/ptt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/ptt_checker.sv
// Port-level checker for the periodic timer table, with its bind.
// Depends on ptt_pkg and periodic_timer_table.
module ptt_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input ptt_pkg::out_item_t out_data
);
  import ptt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_answer_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind != RK_FIRE |->
      out_data.last && out_data.fired_handler == '0)
    else $error("answer beat without last or with a handler");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == RK_FIRE |-> out_data.success)
    else $error("fire beat without success");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
